// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator: request kinds,
// result status codes, field widths and the free stack command bundle.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Fixed field widths
  localparam int PAGE_W   = 14;
  localparam int REF_W    = 8;
  localparam int FCOUNT_W = 15;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;

  // Default number of page frames
  localparam int NUM_PAGES_DEF = 16384;

  // Largest reference count
  localparam logic [REF_W-1:0] REF_MAX = '1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 3'd0,
    KIND_FREE   = 3'd1,
    KIND_ADDREF = 3'd2,
    KIND_SEED   = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_BAD   = 3'd2,
    ST_HELD  = 3'd3,
    ST_SAT   = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  // Free stack update for one item
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [PAGE_W-1:0] push_page;
  } stack_cmd_t;

endpackage

// ----- rtl/pfa_cfg.sv -----
// ----------------------------------------------------------------------------
// pfa_cfg
// APB-style register port holding the first usable page.
// ----------------------------------------------------------------------------
module pfa_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pfa_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output logic [pfa_pkg::PAGE_W-1:0]       first_page
);

  logic [pfa_pkg::PAGE_W-1:0] first_page_r;
  logic                       sel_first;

  // Register 0 lives at byte address 0; low two bits are byte offset
  assign sel_first  = (cfg_paddr[pfa_pkg::CFG_ADDR_W-1:2] == '0);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_first) begin
      first_page_r <= cfg_pwdata[pfa_pkg::PAGE_W-1:0];
    end
  end

  // Read back
  assign cfg_prdata = sel_first ?
      {{(pfa_pkg::CFG_DATA_W-pfa_pkg::PAGE_W){1'b0}}, first_page_r} : '0;
  assign first_page = first_page_r;

endmodule

// ----- rtl/pfa_ref_mem.sv -----
// ----------------------------------------------------------------------------
// pfa_ref_mem
// Reference count table: one synchronous memory, one read and one write
// port, read data registered. Cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module pfa_ref_mem #(
  parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
  parameter int IDX_W     = $clog2(NUM_PAGES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [pfa_pkg::REF_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [pfa_pkg::REF_W-1:0] wr_data,
  output logic                      ready
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

  logic [pfa_pkg::REF_W-1:0] mem [NUM_PAGES];
  logic [pfa_pkg::REF_W-1:0] rd_data_r;
  logic                      clr_busy_r;
  logic [IDX_W-1:0]          clr_addr_r;

  // Clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Storage: sweep owns the write port while busy
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

// ----- rtl/pfa_stack.sv -----
// ----------------------------------------------------------------------------
// pfa_stack
// Free frame stack: synchronous memory plus depth counter. The top entry
// is read into a register ahead of a pop.
// ----------------------------------------------------------------------------
module pfa_stack #(
  parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
  parameter int IDX_W     = $clog2(NUM_PAGES),
  parameter int DEPTH_W   = $clog2(NUM_PAGES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  output logic [pfa_pkg::PAGE_W-1:0]  top_page,
  input  pfa_pkg::stack_cmd_t         cmd,
  output logic [DEPTH_W-1:0]          depth,
  output logic                        empty,
  output logic                        full
);

  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(NUM_PAGES);

  logic [pfa_pkg::PAGE_W-1:0] mem [NUM_PAGES];
  logic [pfa_pkg::PAGE_W-1:0] top_page_r;
  logic [DEPTH_W-1:0]         depth_r;
  logic [DEPTH_W-1:0]         top_idx;

  assign top_idx = depth_r - 1'b1;

  // Depth counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.push) begin
      depth_r <= depth_r + 1'b1;
    end else if (cmd.pop) begin
      depth_r <= depth_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth_r[IDX_W-1:0]] <= cmd.push_page;
    end
    if (rd_en) begin
      top_page_r <= mem[top_idx[IDX_W-1:0]];
    end
  end

  assign top_page = top_page_r;
  assign depth    = depth_r;
  assign empty    = (depth_r == '0);
  assign full     = (depth_r == FULL_DEPTH);

endmodule

// ----- rtl/page_frame_allocator_refcount.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame allocator with a LIFO free stack and 8-bit reference counts.
//
//   channel   dir  signals                            content
//   in_       in   tvalid tready tdata tuser          request: kind, page
//   out_      out  tvalid tready tdata tuser          result: status, page, counts
//   cfg_      in   psel penable pwrite paddr pwdata   first usable page
//
// For each item the accept edge launches the reads of the count table and
// of the stack top; the edge that ends the write-back cycle writes both
// memories back and loads the output register. A new item is taken once
// that is done. After reset the count table is swept to zero, with
// in_tready low. A result waiting on out_tready holds the block in its
// write-back cycle; one result may wait while the next item is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
  parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,    // [13:0] page, [15:14] zero
  input  logic [2:0]                     in_tuser,    // [2:0] kind
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,   // [13:0] alloc_page,
                                                      // [21:14] ref_count,
                                                      // [36:22] free_count,
                                                      // [39:37] zero
  output logic [2:0]                     out_tuser,   // [2:0] status
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pfa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pfa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int PW      = pfa_pkg::PAGE_W;
  localparam int RW      = pfa_pkg::REF_W;
  localparam int FW      = pfa_pkg::FCOUNT_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                 state_r;
  pfa_pkg::kind_t         kind_r;
  logic [PW-1:0]          page_r;
  logic                   out_valid_r;
  pfa_pkg::status_t       out_status_r;
  logic [PW-1:0]          out_page_r;
  logic [RW-1:0]          out_ref_r;
  logic [FW-1:0]          out_free_r;

  logic [PW-1:0]          first_page;
  logic                   in_accept;
  logic                   go;
  logic                   ref_ready;
  logic [RW-1:0]          ref_rd;
  logic [PW-1:0]          stk_top;
  logic [DEPTH_W-1:0]     depth;
  logic [DEPTH_W-1:0]     depth_nxt;
  logic                   stk_empty;
  logic                   stk_full;
  logic                   in_top;
  logic                   usable;
  logic [PW+IDX_W-1:0]    in_idx_w;
  logic [PW+IDX_W-1:0]    pg_idx_w;
  logic [PW+IDX_W-1:0]    top_idx_w;
  logic [DEPTH_W+FW-1:0]  depth_w;

  // Computed result and memory updates
  pfa_pkg::status_t       status_nxt;
  logic [PW-1:0]          alloc_nxt;
  logic [RW-1:0]          count_nxt;
  logic                   ref_we;
  logic [IDX_W-1:0]       ref_wa;
  logic [RW-1:0]          ref_wd;
  logic                   ref_we_q;
  pfa_pkg::stack_cmd_t    stk_cmd;
  pfa_pkg::stack_cmd_t    stk_cmd_q;

  // Handshake
  assign in_tready = (state_r == S_IDLE) && ref_ready;
  assign in_accept = in_tvalid && in_tready;
  assign go        = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Page to memory index, valid whichever of the two widths is wider
  assign in_idx_w  = {{IDX_W{1'b0}}, in_tdata[PW-1:0]};
  assign pg_idx_w  = {{IDX_W{1'b0}}, page_r};
  assign top_idx_w = {{IDX_W{1'b0}}, stk_top};

  // Range checks
  assign in_top = 32'(page_r) < 32'(NUM_PAGES);
  assign usable = in_top && (page_r >= first_page);

  // Request decode and count update
  always_comb begin
    status_nxt = pfa_pkg::ST_OK;
    alloc_nxt  = '0;
    count_nxt  = '0;
    ref_we     = 1'b0;
    ref_wa     = pg_idx_w[IDX_W-1:0];
    ref_wd     = '0;
    stk_cmd    = '{pop: 1'b0, push: 1'b0, push_page: page_r};
    case (kind_r)
      pfa_pkg::KIND_ALLOC: begin
        if (stk_empty) begin
          status_nxt = pfa_pkg::ST_EMPTY;
        end else begin
          alloc_nxt   = stk_top;
          count_nxt   = RW'(1);
          ref_we      = 1'b1;
          ref_wa      = top_idx_w[IDX_W-1:0];
          ref_wd      = RW'(1);
          stk_cmd.pop = 1'b1;
        end
      end
      pfa_pkg::KIND_FREE: begin
        if (!usable) begin
          status_nxt = pfa_pkg::ST_BAD;
        end else begin
          count_nxt = (ref_rd != '0) ? ref_rd - 1'b1 : '0;
          ref_we    = 1'b1;
          ref_wd    = count_nxt;
          if (count_nxt != '0) begin
            status_nxt = pfa_pkg::ST_HELD;
          end else if (stk_full) begin
            status_nxt = pfa_pkg::ST_FULL;
          end else begin
            stk_cmd.push = 1'b1;
          end
        end
      end
      pfa_pkg::KIND_ADDREF: begin
        if (!in_top) begin
          status_nxt = pfa_pkg::ST_BAD;
        end else if (ref_rd == pfa_pkg::REF_MAX) begin
          status_nxt = pfa_pkg::ST_SAT;
          count_nxt  = pfa_pkg::REF_MAX;
        end else begin
          count_nxt = ref_rd + 1'b1;
          ref_we    = 1'b1;
          ref_wd    = count_nxt;
        end
      end
      pfa_pkg::KIND_SEED: begin
        if (!usable) begin
          status_nxt = pfa_pkg::ST_BAD;
        end else if (stk_full) begin
          status_nxt = pfa_pkg::ST_FULL;
          count_nxt  = ref_rd;
        end else begin
          ref_we       = 1'b1;
          ref_wd       = '0;
          stk_cmd.push = 1'b1;
        end
      end
      pfa_pkg::KIND_QUERY: begin
        if (!in_top) begin
          status_nxt = pfa_pkg::ST_BAD;
        end else begin
          count_nxt = ref_rd;
        end
      end
      default: begin
        status_nxt = pfa_pkg::ST_OK;
      end
    endcase
  end

  // Updates commit only in the write-back cycle
  assign ref_we_q  = ref_we && go;
  assign stk_cmd_q = '{pop:       stk_cmd.pop && go,
                       push:      stk_cmd.push && go,
                       push_page: stk_cmd.push_page};

  // Free count after this item
  always_comb begin
    depth_nxt = depth;
    if (stk_cmd.push) begin
      depth_nxt = depth + 1'b1;
    end else if (stk_cmd.pop) begin
      depth_nxt = depth - 1'b1;
    end
  end
  assign depth_w = {{FW{1'b0}}, depth_nxt};

  // Control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            kind_r  <= pfa_pkg::kind_t'(in_tuser);
            page_r  <= in_tdata[PW-1:0];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_nxt;
            out_page_r   <= alloc_nxt;
            out_ref_r    <= count_nxt;
            out_free_r   <= depth_w[FW-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_free_r, out_ref_r, out_page_r};

  // Configuration register
  pfa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .first_page  (first_page)
  );

  // Reference count table
  pfa_ref_mem #(
    .NUM_PAGES (NUM_PAGES),
    .IDX_W     (IDX_W)
  ) u_ref_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_idx_w[IDX_W-1:0]),
    .rd_data (ref_rd),
    .wr_en   (ref_we_q),
    .wr_addr (ref_wa),
    .wr_data (ref_wd),
    .ready   (ref_ready)
  );

  // Free frame stack
  pfa_stack #(
    .NUM_PAGES (NUM_PAGES),
    .IDX_W     (IDX_W),
    .DEPTH_W   (DEPTH_W)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .top_page (stk_top),
    .cmd      (stk_cmd_q),
    .depth    (depth),
    .empty    (stk_empty),
    .full     (stk_full)
  );

endmodule
